// ===== design/vct_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vct_pkg: shared definitions for the vector clock table
// Word layouts, operation and ordering codes, sequencer states and the
// ordering fold used when a comparison is judged.
// ---------------------------------------------------------------------------
package vct_pkg;

    // Default number of table entries.
    localparam int VECTOR_DEPTH_DEF = 16;

    // Operation codes carried in the request word.
    localparam logic [1:0] OP_CLEAR     = 2'd0;
    localparam logic [1:0] OP_INCREMENT = 2'd1;
    localparam logic [1:0] OP_COMPARE   = 2'd2;
    localparam logic [1:0] OP_FINISH    = 2'd3;

    // Ordering codes, peer clock relative to the local clock.
    localparam logic [1:0] ORD_EQUAL    = 2'd0;
    localparam logic [1:0] ORD_BEFORE   = 2'd1;
    localparam logic [1:0] ORD_AFTER    = 2'd2;
    localparam logic [1:0] ORD_CONFLICT = 2'd3;

    // Answer kinds on the result word.
    localparam logic KIND_INCREMENT = 1'b0;
    localparam logic KIND_VERDICT   = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] member_addr;
        logic [31:0] member_uid;
        logic [31:0] peer_seq;
    } request_t;

    typedef struct packed {
        logic        answer_kind;
        logic [31:0] new_seq;
        logic [1:0]  order;
    } result_t;

    // One table entry as held in the table memory.
    typedef struct packed {
        logic [63:0] addr;
        logic [31:0] uid;
        logic [31:0] seq;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // Merge a new judgement into the running order; conflict is sticky.
    function automatic logic [1:0] fold_order(input logic [1:0] prev, input logic [1:0] nxt);
        logic [1:0] res;
        if (prev != ORD_EQUAL && nxt != prev) begin
            res = ORD_CONFLICT;
        end
        else begin
            res = nxt;
        end
        return res;
    endfunction

endpackage

// ===== design/vct_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vct_ram: generic single-write, single-read memory
// One write port and one read port with a registered read word.
// ---------------------------------------------------------------------------
module vct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/vector_clock_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_clock_table: bounded vector clock with peer comparison
// Keeps member identifiers and wrapping sequence numbers in a small table
// memory, searched one entry per cycle by a single shared identifier
// comparator under a three-state sequencer.
// ---------------------------------------------------------------------------
// Increment and compare read the table entry by entry through the single memory
// read port, whose registered read word feeds the comparator, and then pass
// through the update state; busy is high meanwhile.
// Clear and finish are handled in the idle state and leave busy low.
// Increment and finish give one result word, strobed for one cycle on the
// cycle after the item completes; the receiver cannot stall it.
// Reset empties the table and returns the running order to equal; no
// clearing pass is needed since only entries below entry_count are read.
// ---------------------------------------------------------------------------
module vector_clock_table #(
    parameter int VECTOR_DEPTH = vct_pkg::VECTOR_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  vct_pkg::request_t request,
    output logic             result_valid,
    output vct_pkg::result_t result
);

    // Index width for the table, and a count width able to hold the depth itself.
    localparam int IDX_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int CNT_W = $clog2(VECTOR_DEPTH + 1);
    localparam int ENTRY_W = $bits(vct_pkg::entry_t);

    // Sequencer and search state.
    vct_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [31:0]       hit_seq_reg, hit_seq_next;
    vct_pkg::request_t req_reg, req_next;

    // Architectural clock state.
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic [VECTOR_DEPTH-1:0] visited_reg, visited_next;
    logic [1:0]              order_reg, order_next;

    // Result word.
    logic             res_valid_reg, res_valid_next;
    vct_pkg::result_t res_reg, res_next;

    // Table memory ports.
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    vct_pkg::entry_t    wr_entry;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_word;
    vct_pkg::entry_t    rd_entry;

    logic               accept;
    logic               hit;
    logic               scan_more;
    logic [VECTOR_DEPTH-1:0] full_mask;
    logic [1:0]         verdict;
    logic [31:0]        inc_seq;
    logic [1:0]         judgement;

    vct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_data (rd_word)
    );

    assign rd_entry = vct_pkg::entry_t'(rd_word);

    assign busy   = (state_reg != vct_pkg::ST_IDLE);
    assign accept = start && !busy;

    // The shared comparator: the entry read in the previous cycle against the
    // identifier being looked up.
    assign hit = (state_reg == vct_pkg::ST_SCAN) && pend_reg &&
                 (rd_entry.addr == req_reg.member_addr) &&
                 (rd_entry.uid == req_reg.member_uid);

    // More table entries remain to be read.
    assign scan_more = (scan_reg < count_reg);

    // Entries below entry_count, all of which a full comparison must visit.
    always_comb
    begin
        for (int i = 0; i < VECTOR_DEPTH; i++)
        begin
            full_mask[i] = (CNT_W'(i) < count_reg);
        end
    end

    // Finish verdict: any unvisited local entry means the local side is ahead.
    always_comb
    begin
        verdict = order_reg;
        if ((visited_reg & full_mask) != full_mask)
        begin
            verdict = vct_pkg::fold_order(order_reg, vct_pkg::ORD_BEFORE);
        end
    end

    assign inc_seq = hit_seq_reg + 32'd1;

    // Judgement of one peer record, used in the update cycle of a compare.
    always_comb
    begin
        if (!found_reg)
        begin
            judgement = vct_pkg::ORD_AFTER;
        end
        else if (req_reg.peer_seq > hit_seq_reg)
        begin
            judgement = vct_pkg::ORD_AFTER;
        end
        else if (hit_seq_reg > req_reg.peer_seq)
        begin
            judgement = vct_pkg::ORD_BEFORE;
        end
        else
        begin
            judgement = vct_pkg::ORD_EQUAL;
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vct_pkg::ST_IDLE:
            begin
                if (accept && (request.operation == vct_pkg::OP_INCREMENT ||
                               request.operation == vct_pkg::OP_COMPARE))
                begin
                    state_next = vct_pkg::ST_SCAN;
                end
            end
            vct_pkg::ST_SCAN:
            begin
                if (hit || !scan_more)
                begin
                    state_next = vct_pkg::ST_UPDATE;
                end
            end
            vct_pkg::ST_UPDATE:
            begin
                state_next = vct_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vct_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and result word for each state.
    always_comb
    begin
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_seq_next   = hit_seq_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        visited_next   = visited_reg;
        order_next     = order_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_entry       = '{addr: req_reg.member_addr, uid: req_reg.member_uid, seq: 32'd1};
        rd_en          = 1'b0;

        case (state_reg)
            vct_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.operation)
                        vct_pkg::OP_CLEAR:
                        begin
                            count_next   = '0;
                            ptr_next     = '0;
                            visited_next = '0;
                            order_next   = vct_pkg::ORD_EQUAL;
                        end
                        vct_pkg::OP_FINISH:
                        begin
                            res_valid_next = 1'b1;
                            res_next = '{answer_kind: vct_pkg::KIND_VERDICT,
                                         new_seq: 32'd0, order: verdict};
                            visited_next = '0;
                            order_next   = vct_pkg::ORD_EQUAL;
                        end
                        default:
                        begin
                            // Increment or compare: start a search from entry zero.
                            req_next  = request;
                            scan_next = '0;
                        end
                    endcase
                end
            end
            vct_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    found_next   = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    hit_seq_next = rd_entry.seq;
                end
                else if (scan_more)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else
                begin
                    found_next = 1'b0;
                end
            end
            vct_pkg::ST_UPDATE:
            begin
                if (req_reg.operation == vct_pkg::OP_INCREMENT)
                begin
                    wr_en          = 1'b1;
                    res_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        wr_addr  = hit_idx_reg;
                        wr_entry = '{addr: req_reg.member_addr, uid: req_reg.member_uid,
                                     seq: inc_seq};
                        res_next = '{answer_kind: vct_pkg::KIND_INCREMENT,
                                     new_seq: inc_seq, order: vct_pkg::ORD_EQUAL};
                    end
                    else
                    begin
                        // New member goes in at the ring pointer with sequence one.
                        res_next = '{answer_kind: vct_pkg::KIND_INCREMENT,
                                     new_seq: 32'd1, order: vct_pkg::ORD_EQUAL};
                        if (count_reg < CNT_W'(VECTOR_DEPTH))
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        if (ptr_reg == IDX_W'(VECTOR_DEPTH - 1))
                        begin
                            ptr_next = '0;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + IDX_W'(1);
                        end
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        visited_next[hit_idx_reg] = 1'b1;
                    end
                    if (judgement != vct_pkg::ORD_EQUAL)
                    begin
                        order_next = vct_pkg::fold_order(order_reg, judgement);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vct_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            visited_reg   <= '0;
            order_reg     <= vct_pkg::ORD_EQUAL;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            visited_reg   <= visited_next;
            order_reg     <= order_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        hit_idx_reg  <= hit_idx_next;
        hit_seq_reg  <= hit_seq_next;
        req_reg      <= req_next;
        res_reg      <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== tb/tb_vector_clock_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_vector_clock_table: self-checking bench for the vector clock table
// Drives request words through the start/busy handshake and checks every
// result word against a bench-side model of the member table, the ring
// insert pointer and the running comparison order. A short directed table
// comes first, then three random phases with different sender idling.
// ---------------------------------------------------------------------------
module tb_vector_clock_table;

    localparam int DEPTH     = vct_pkg::VECTOR_DEPTH_DEF;
    localparam int POOL_SIZE = 20;
    localparam int N_ROWS    = 25;

    // One row of the directed table. Where typed is set the expected answer
    // is written into the row; otherwise the table model supplies it.
    typedef struct {
        vct_pkg::request_t word;
        bit                typed;
        vct_pkg::result_t  want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    vct_pkg::request_t req_word;
    logic              answer_strobe;
    vct_pkg::result_t  answer_word;

    vector_clock_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (req_word),
        .result_valid (answer_strobe),
        .result       (answer_word)
    );

    // -----------------------------------------------------------------------
    // Bench copy of the member table and the comparison state.
    // -----------------------------------------------------------------------
    logic [63:0] tbl_addr [DEPTH];
    logic [31:0] tbl_uid  [DEPTH];
    logic [31:0] tbl_seq  [DEPTH];
    int          live_count;
    int          ins_ptr;
    logic [15:0] seen_mask;
    logic [1:0]  run_order;

    // Answers still owed by the block, oldest first.
    vct_pkg::result_t expected_answers [$];

    // Member identifiers that the random part draws from. The pool is a
    // little larger than the table so that the ring pointer overwrites.
    logic [63:0] pool_addr [POOL_SIZE];
    logic [31:0] pool_uid  [POOL_SIZE];

    stim_row_t stim_rows [N_ROWS];

    int idle_pct;
    int words_sent;
    int answers_checked;
    int mismatches;
    int verdict_tally [4];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a correct run finishes in well under a tenth of this time.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Table model
    // -----------------------------------------------------------------------
    function automatic void wipe_table();
        live_count = 0;
        ins_ptr    = 0;
        seen_mask  = '0;
        run_order  = vct_pkg::ORD_EQUAL;
    endfunction

    // Search stops at the live count, exactly as the block does, so stale
    // entries left behind by a clear are never matched.
    function automatic int find_member(input logic [63:0] a, input logic [31:0] u);
        for (int i = 0; i < live_count; i++)
        begin
            if (tbl_addr[i] == a && tbl_uid[i] == u)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    // A judgement that disagrees with a settled order turns it into conflict,
    // and conflict then stays until the next finish or clear.
    function automatic logic [1:0] merge_order(input logic [1:0] held, input logic [1:0] judged);
        if (held != vct_pkg::ORD_EQUAL && judged != held)
        begin
            return vct_pkg::ORD_CONFLICT;
        end
        return judged;
    endfunction

    // Applies one accepted word to the model and says whether it owes an
    // answer, and which.
    function automatic void apply_word(input vct_pkg::request_t w, output bit gives,
                                       output vct_pkg::result_t ans);
        int          idx;
        logic [15:0] need;
        gives = 1'b0;
        ans   = '0;
        case (w.operation)
            vct_pkg::OP_CLEAR:
            begin
                wipe_table();
            end
            vct_pkg::OP_INCREMENT:
            begin
                idx = find_member(w.member_addr, w.member_uid);
                if (idx < 0)
                begin
                    // A new member lands at the ring pointer with sequence one.
                    tbl_addr[ins_ptr] = w.member_addr;
                    tbl_uid[ins_ptr]  = w.member_uid;
                    tbl_seq[ins_ptr]  = 32'd1;
                    idx = ins_ptr;
                    if (live_count < DEPTH)
                    begin
                        live_count++;
                    end
                    ins_ptr = (ins_ptr + 1) % DEPTH;
                end
                else
                begin
                    tbl_seq[idx] = tbl_seq[idx] + 32'd1;
                end
                gives           = 1'b1;
                ans.answer_kind = vct_pkg::KIND_INCREMENT;
                ans.new_seq     = tbl_seq[idx];
                ans.order       = vct_pkg::ORD_EQUAL;
            end
            vct_pkg::OP_COMPARE:
            begin
                idx = find_member(w.member_addr, w.member_uid);
                if (idx < 0)
                begin
                    run_order = merge_order(run_order, vct_pkg::ORD_AFTER);
                end
                else
                begin
                    seen_mask[idx] = 1'b1;
                    if (w.peer_seq > tbl_seq[idx])
                    begin
                        run_order = merge_order(run_order, vct_pkg::ORD_AFTER);
                    end
                    else if (w.peer_seq < tbl_seq[idx])
                    begin
                        run_order = merge_order(run_order, vct_pkg::ORD_BEFORE);
                    end
                end
            end
            default:
            begin
                // Finish: any live entry the peer never mentioned counts as
                // the local clock being ahead there.
                need = (live_count >= 16) ? 16'hFFFF : 16'((32'd1 << live_count) - 1);
                gives           = 1'b1;
                ans.answer_kind = vct_pkg::KIND_VERDICT;
                ans.new_seq     = '0;
                ans.order       = run_order;
                if ((seen_mask & need) != need)
                begin
                    ans.order = merge_order(run_order, vct_pkg::ORD_BEFORE);
                end
                run_order = vct_pkg::ORD_EQUAL;
                seen_mask = '0;
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Sender
    // -----------------------------------------------------------------------
    // Offers one word, holding it until the block takes it, and records the
    // answer it owes. Idle cycles before the offer fall wherever the block
    // happens to be in its work.
    task automatic send_word(input vct_pkg::request_t w, input bit typed,
                             input vct_pkg::result_t want);
        bit               gives;
        vct_pkg::result_t ans;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        req_word <= w;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        apply_word(w, gives, ans);
        if (gives)
        begin
            if (typed)
            begin
                ans = want;
            end
            expected_answers.push_back(ans);
            if (ans.answer_kind == vct_pkg::KIND_VERDICT)
            begin
                verdict_tally[ans.order]++;
            end
        end
        words_sent++;
    endtask

    function automatic vct_pkg::request_t make_word(input logic [1:0] op,
                                                    input logic [63:0] a,
                                                    input logic [31:0] u,
                                                    input logic [31:0] p);
        vct_pkg::request_t w;
        w.operation   = op;
        w.member_addr = a;
        w.member_uid  = u;
        w.peer_seq    = p;
        return w;
    endfunction

    function automatic stim_row_t make_row(input logic [1:0] op, input logic [63:0] a,
                                           input logic [31:0] u, input logic [31:0] p,
                                           input bit typed, input logic [31:0] seq,
                                           input logic [1:0] ord);
        stim_row_t r;
        r.word             = make_word(op, a, u, p);
        r.typed            = typed;
        r.want.answer_kind = (op == vct_pkg::OP_INCREMENT) ? vct_pkg::KIND_INCREMENT
                                                           : vct_pkg::KIND_VERDICT;
        r.want.new_seq     = seq;
        r.want.order       = ord;
        return r;
    endfunction

    // Fresh random identifiers, with two pairs that share one half of the
    // identifier so that a half match must still miss.
    function automatic void refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_addr[i] = {$urandom, $urandom};
            pool_uid[i]  = $urandom;
        end
        pool_addr[3] = pool_addr[2];
        pool_uid[5]  = pool_uid[4];
    endfunction

    // Peer sequence numbers mostly sit on or next to the local one, so that
    // all three judgements happen often.
    function automatic logic [31:0] peer_near(input logic [31:0] local_seq);
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
        begin
            return local_seq;
        end
        else if (pick < 6)
        begin
            return local_seq + 32'd1;
        end
        else if (pick < 8)
        begin
            return local_seq - 32'd1;
        end
        else if (pick == 8)
        begin
            return $urandom;
        end
        return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endfunction

    // A peer clock streamed as a handful of records, drawn mostly from the
    // live table, usually closed by a finish.
    task automatic compare_session();
        int                n;
        int                k;
        vct_pkg::request_t w;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++)
        begin
            if (live_count > 0 && $urandom_range(99) < 75)
            begin
                k = $urandom_range(live_count - 1);
                w = make_word(vct_pkg::OP_COMPARE, tbl_addr[k], tbl_uid[k],
                              peer_near(tbl_seq[k]));
            end
            else
            begin
                k = $urandom_range(POOL_SIZE - 1);
                w = make_word(vct_pkg::OP_COMPARE, pool_addr[k], pool_uid[k],
                              peer_near(32'd2));
            end
            send_word(w, 1'b0, '0);
        end
        if ($urandom_range(99) < 85)
        begin
            send_word(make_word(vct_pkg::OP_FINISH, {$urandom, $urandom}, $urandom,
                                $urandom), 1'b0, '0);
        end
    endtask

    // A peer clock that mirrors the local one, now and then with an entry
    // left out or nudged, so that equal verdicts turn up as well.
    task automatic mirror_session();
        int          live_now;
        logic [31:0] p;
        live_now = live_count;
        for (int i = 0; i < live_now; i++)
        begin
            if ($urandom_range(99) >= 8)
            begin
                p = ($urandom_range(99) < 8) ? peer_near(tbl_seq[i]) : tbl_seq[i];
                send_word(make_word(vct_pkg::OP_COMPARE, tbl_addr[i], tbl_uid[i], p),
                          1'b0, '0);
            end
        end
        send_word(make_word(vct_pkg::OP_FINISH, {$urandom, $urandom}, $urandom, $urandom),
                  1'b0, '0);
    endtask

    task automatic random_phase(input int last_word, input int pct);
        int                pick;
        int                k;
        vct_pkg::request_t w;
        idle_pct = pct;
        while (words_sent < last_word)
        begin
            pick = $urandom_range(99);
            if (pick < 42)
            begin
                k = $urandom_range(POOL_SIZE - 1);
                w = make_word(vct_pkg::OP_INCREMENT, pool_addr[k], pool_uid[k], $urandom);
                if ($urandom_range(99) < 5)
                begin
                    w.member_addr = {$urandom, $urandom};
                    w.member_uid  = $urandom;
                end
                send_word(w, 1'b0, '0);
            end
            else if (pick < 64)
            begin
                compare_session();
            end
            else if (pick < 78)
            begin
                mirror_session();
            end
            else if (pick < 82)
            begin
                send_word(make_word(vct_pkg::OP_CLEAR, {$urandom, $urandom}, $urandom,
                                    $urandom), 1'b0, '0);
                if ($urandom_range(1))
                begin
                    refill_pool();
                end
            end
            else if (pick < 88)
            begin
                send_word(make_word(vct_pkg::OP_FINISH, {$urandom, $urandom}, $urandom,
                                    $urandom), 1'b0, '0);
            end
            else
            begin
                // Noise: any operation with unrelated fields.
                send_word(make_word(2'($urandom), {$urandom, $urandom}, $urandom, $urandom),
                          1'b0, '0);
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Answer checker: every strobed word must match the oldest expectation.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : answer_check
        vct_pkg::result_t want;
        if (rst_n && answer_strobe)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected answer word, got kind %0d seq %0d order %0d",
                         $time, answer_word.answer_kind, answer_word.new_seq,
                         answer_word.order);
            end
            else
            begin
                want = expected_answers.pop_front();
                answers_checked++;
                if (answer_word.answer_kind !== want.answer_kind)
                begin
                    mismatches++;
                    $display("%0t: answer_kind expected %0d got %0d",
                             $time, want.answer_kind, answer_word.answer_kind);
                end
                if (answer_word.new_seq !== want.new_seq)
                begin
                    mismatches++;
                    $display("%0t: new_seq expected %0d got %0d",
                             $time, want.new_seq, answer_word.new_seq);
                end
                if (answer_word.order !== want.order)
                begin
                    mismatches++;
                    $display("%0t: order expected %0d got %0d",
                             $time, want.order, answer_word.order);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin : main_flow
        int waited;
        rst_n           = 1'b0;
        start           = 1'b0;
        req_word        = '0;
        idle_pct        = 0;
        words_sent      = 0;
        answers_checked = 0;
        mismatches      = 0;
        verdict_tally   = '{default: 0};
        wipe_table();
        refill_pool();

        // Directed table. Member A is all zeros, member B all ones and C a
        // checker pattern; the last row shares A's address but not its uid.
        stim_rows[0]  = make_row(vct_pkg::OP_FINISH, 64'h0, 32'h0, 32'h0, 1'b1, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[1]  = make_row(vct_pkg::OP_INCREMENT, 64'h0, 32'h0, 32'hFFFF_FFFF, 1'b1,
                                 32'd1, vct_pkg::ORD_EQUAL);
        stim_rows[2]  = make_row(vct_pkg::OP_INCREMENT, 64'h0, 32'h0, 32'h0, 1'b1, 32'd2,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[3]  = make_row(vct_pkg::OP_INCREMENT, '1, '1, 32'h0, 1'b1, 32'd1,
                                 vct_pkg::ORD_EQUAL);
        // Peer identical to the local clock.
        stim_rows[4]  = make_row(vct_pkg::OP_COMPARE, 64'h0, 32'h0, 32'd2, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[5]  = make_row(vct_pkg::OP_COMPARE, '1, '1, 32'd1, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[6]  = make_row(vct_pkg::OP_FINISH, 64'h0, 32'h0, 32'h0, 1'b1, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        // Peer ahead on one member.
        stim_rows[7]  = make_row(vct_pkg::OP_COMPARE, 64'h0, 32'h0, 32'd3, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[8]  = make_row(vct_pkg::OP_COMPARE, '1, '1, 32'd1, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[9]  = make_row(vct_pkg::OP_FINISH, 64'h0, 32'h0, 32'h0, 1'b1, 32'd0,
                                 vct_pkg::ORD_AFTER);
        // Peer behind, and silent about B.
        stim_rows[10] = make_row(vct_pkg::OP_COMPARE, 64'h0, 32'h0, 32'h0, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[11] = make_row(vct_pkg::OP_FINISH, 64'h0, 32'h0, 32'h0, 1'b1, 32'd0,
                                 vct_pkg::ORD_BEFORE);
        // Peer ahead on one member and behind on the other.
        stim_rows[12] = make_row(vct_pkg::OP_COMPARE, 64'h0, 32'h0, 32'hFFFF_FFFF, 1'b0,
                                 32'd0, vct_pkg::ORD_EQUAL);
        stim_rows[13] = make_row(vct_pkg::OP_COMPARE, '1, '1, 32'h0, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[14] = make_row(vct_pkg::OP_FINISH, 64'h0, 32'h0, 32'h0, 1'b1, 32'd0,
                                 vct_pkg::ORD_CONFLICT);
        // A stranger judges after, the unvisited entries then judge before.
        stim_rows[15] = make_row(vct_pkg::OP_COMPARE, 64'h5555_5555_5555_5555,
                                 32'hAAAA_AAAA, 32'd7, 1'b0, 32'd0, vct_pkg::ORD_EQUAL);
        stim_rows[16] = make_row(vct_pkg::OP_FINISH, 64'h0, 32'h0, 32'h0, 1'b1, 32'd0,
                                 vct_pkg::ORD_CONFLICT);
        // Duplicate peer records are each judged on their own.
        stim_rows[17] = make_row(vct_pkg::OP_COMPARE, 64'h0, 32'h0, 32'd2, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[18] = make_row(vct_pkg::OP_COMPARE, 64'h0, 32'h0, 32'd2, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[19] = make_row(vct_pkg::OP_COMPARE, '1, '1, 32'd1, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[20] = make_row(vct_pkg::OP_FINISH, '1, '1, '1, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        // Clear empties the table, so A starts again from one.
        stim_rows[21] = make_row(vct_pkg::OP_CLEAR, '1, '1, '1, 1'b0, 32'd0,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[22] = make_row(vct_pkg::OP_INCREMENT, 64'h0, 32'h0, 32'h0, 1'b1, 32'd1,
                                 vct_pkg::ORD_EQUAL);
        stim_rows[23] = make_row(vct_pkg::OP_FINISH, 64'h0, 32'h0, 32'h0, 1'b1, 32'd0,
                                 vct_pkg::ORD_BEFORE);
        stim_rows[24] = make_row(vct_pkg::OP_INCREMENT, 64'h0, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                 32'd1, vct_pkg::ORD_EQUAL);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The first two phases keep the sender idle part of the time; the
        // last one offers a new word on every cycle the block can take it.
        idle_pct = 22;
        for (int i = 0; i < N_ROWS; i++)
        begin
            send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);
        end
        random_phase(600, 22);
        random_phase(1175, 69);
        random_phase(1750, 0);
        start <= 1'b0;

        // Drain the owed answers, then give a stray word time to show up.
        waited = 0;
        while (expected_answers.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        if (expected_answers.size() != 0)
        begin
            mismatches += expected_answers.size();
            $display("%0t: %0d answer words never arrived", $time, expected_answers.size());
        end

        $display("Run covered %0d request words and %0d checked answer words.",
                 words_sent, answers_checked);
        $display("Verdicts: %0d equal, %0d before, %0d after, %0d conflict.",
                 verdict_tally[vct_pkg::ORD_EQUAL], verdict_tally[vct_pkg::ORD_BEFORE],
                 verdict_tally[vct_pkg::ORD_AFTER], verdict_tally[vct_pkg::ORD_CONFLICT]);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
